/* design/armpm_pkg.sv */
// armpm_pkg: shared types and constants for the rms/peak level meter
// no dependencies

package armpm_pkg;

  localparam int unsigned CHANNELS_DEF       = 2;
  localparam int unsigned MAX_COUNT_LOG2_DEF = 24;
  localparam int unsigned LOG_FRAC_BITS      = 16;
  localparam int unsigned SUM_W              = 64;
  localparam logic [18:0] K_RMS              = 19'd197283;
  localparam logic [18:0] K_PEAK             = 19'd394566;
  localparam logic signed [15:0] DB_FLOOR    = 16'sh8000;

  typedef struct packed {
    logic              channel;
    logic signed [15:0] sample;
    logic              last;
  } in_item_t;

  typedef struct packed {
    logic              result_channel;
    logic signed [15:0] rms_db;
    logic signed [15:0] peak_db;
    logic              overflowed;
  } out_item_t;

  // request and response between sequencer and log unit
  typedef struct packed {
    logic        start;
    logic [63:0] x;
  } log_req_t;

  typedef struct packed {
    logic               done;
    logic signed [22:0] value;
  } log_rsp_t;

endpackage

/* design/armpm_log2.sv */
// armpm_log2: iterative fixed-point log2, one fraction bit per cycle
// depends on armpm_pkg

module armpm_log2 (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  armpm_pkg::log_req_t  req_i,
  output armpm_pkg::log_rsp_t  rsp_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_NORM = 2'd1;
  localparam logic [1:0] S_ITER = 2'd2;

  localparam int unsigned LOG_FRAC_BITS_M1 = armpm_pkg::LOG_FRAC_BITS - 1;

  logic [1:0]  state_q, state_d;
  logic [63:0] x_q, x_d;
  logic [32:0] m_q, m_d;
  logic [5:0]  e_q, e_d;
  logic [4:0]  bit_q, bit_d;
  logic [15:0] frac_q, frac_d;
  logic        done_q, done_d;

  logic [5:0]  lead;
  logic [65:0] sq;
  logic [34:0] msq;

  // leading one search over the 64-bit operand
  always_comb begin
    lead = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (x_q[i]) lead = 6'(i);
    end
  end

  assign sq  = {33'd0, m_q} * {33'd0, m_q};
  assign msq = sq[65:31];

  always_comb begin
    state_d = state_q;
    x_d     = x_q;
    m_d     = m_q;
    e_d     = e_q;
    bit_d   = bit_q;
    frac_d  = frac_q;
    done_d  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (req_i.start) begin
          x_d     = req_i.x;
          state_d = S_NORM;
        end
      end
      S_NORM: begin
        e_d = lead;
        if (lead >= 6'd31) m_d = 33'(x_q >> (lead - 6'd31));
        else               m_d = 33'(x_q << (6'd31 - lead));
        bit_d   = 5'(LOG_FRAC_BITS_M1);
        frac_d  = '0;
        state_d = S_ITER;
      end
      S_ITER: begin
        if (msq[34:32] != 3'd0) begin
          frac_d[bit_q[3:0]] = 1'b1;
          m_d = msq[33:1];
        end else begin
          m_d = msq[32:0];
        end
        bit_d = bit_q - 5'd1;
        if (bit_q == 5'd0) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    m_q    <= m_d;
    e_q    <= e_d;
    bit_q  <= bit_d;
    frac_q <= frac_d;
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.value = $signed({1'b0, e_q, frac_q});

endmodule

/* design/audio_rms_peak_meter_db_unit.sv */
// audio_rms_peak_meter_db_unit: per-channel rms and peak level meter, dBFS Q8.8
// depends on armpm_pkg and armpm_log2
// a sample without last goes through accept and accumulate, then back to idle
// a last sample goes through accumulate, three log2 runs (each a request, then a wait
//   for done) on the shared log unit, two scale multiplies, then the output load
// no new item is taken until the previous one is through and its result is taken
// reset clears all channel accumulators, the sequencer and the output valid

module audio_rms_peak_meter_db_unit #(
  parameter int unsigned CHANNELS       = armpm_pkg::CHANNELS_DEF,
  parameter int unsigned MAX_COUNT_LOG2 = armpm_pkg::MAX_COUNT_LOG2_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  armpm_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output armpm_pkg::out_item_t out_item_o
);

  localparam int unsigned CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned CNT_W = MAX_COUNT_LOG2;

  // sequencer codes
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ACC   = 4'd1;
  localparam logic [3:0] S_LSUM  = 4'd2;
  localparam logic [3:0] S_WSUM  = 4'd3;
  localparam logic [3:0] S_LCNT  = 4'd4;
  localparam logic [3:0] S_WCNT  = 4'd5;
  localparam logic [3:0] S_LPK   = 4'd6;
  localparam logic [3:0] S_WPK   = 4'd7;
  localparam logic [3:0] S_MRMS  = 4'd8;
  localparam logic [3:0] S_MPK   = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  // per-channel accumulators
  logic [63:0]    sum_q  [CHANNELS];
  logic [CNT_W:0] cnt_q  [CHANNELS];
  logic [16:0]    peak_q [CHANNELS];
  logic           ovf_q  [CHANNELS];

  logic [3:0]  state_q, state_d;
  armpm_pkg::in_item_t item_q;
  logic [CH_W-1:0] ch_q;
  logic signed [22:0] lsum_q, lcnt_q, lpk_q;
  logic signed [22:0] dlog;
  logic signed [41:0] prod;
  logic signed [15:0] rms_q;
  logic [16:0] mag;
  logic [31:0] sq;
  logic        in_range;

  armpm_pkg::log_req_t lreq;
  armpm_pkg::log_rsp_t lrsp;
  armpm_pkg::out_item_t out_q;
  logic out_valid_q;

  armpm_log2 u_log2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (lreq),
    .rsp_o  (lrsp)
  );

  // take a new item only with the sequencer idle and no result pending
  assign in_ready_o = (state_q == S_IDLE) && !out_valid_q;

  assign ch_q     = CH_W'(item_q.channel);
  assign in_range = 32'(item_q.channel) < CHANNELS;
  assign mag      = item_q.sample[15] ? (17'h10000 - {1'b0, item_q.sample})
                                      : {1'b0, item_q.sample};
  assign sq       = 32'(mag) * 32'(mag);

  // log operand selection for the single shared log unit
  always_comb begin
    lreq.start = 1'b0;
    lreq.x     = '0;
    case (state_q)
      S_LSUM: begin lreq.start = 1'b1; lreq.x = sum_q[ch_q]; end
      S_LCNT: begin lreq.start = 1'b1; lreq.x = 64'(cnt_q[ch_q]); end
      S_LPK:  begin lreq.start = 1'b1; lreq.x = 64'(peak_q[ch_q]); end
      default: ;
    endcase
  end

  // one shared multiplier for both dB scalings
  always_comb begin
    if (state_q == S_MRMS) begin
      dlog = lsum_q - lcnt_q - 23'sd1966080;
      prod = 42'(dlog) * $signed({23'd0, armpm_pkg::K_RMS});
    end else begin
      dlog = lpk_q - 23'sd983040;
      prod = 42'(dlog) * $signed({23'd0, armpm_pkg::K_PEAK});
    end
  end

  function automatic logic signed [15:0] to_db(input logic signed [41:0] p);
    logic signed [41:0] r;
    r = (p + 42'sd8388608) >>> 24;
    if (r > 42'sd0)           return 16'sd0;
    else if (r < -42'sd32768) return armpm_pkg::DB_FLOOR;
    else                      return r[15:0];
  endfunction

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_valid_i && in_ready_o) state_d = S_ACC;
      S_ACC:   state_d = (in_range && item_q.last) ? S_LSUM : S_IDLE;
      S_LSUM:  state_d = S_WSUM;
      S_WSUM:  if (lrsp.done) state_d = S_LCNT;
      S_LCNT:  state_d = S_WCNT;
      S_WCNT:  if (lrsp.done) state_d = S_LPK;
      S_LPK:   state_d = S_WPK;
      S_WPK:   if (lrsp.done) state_d = S_MRMS;
      S_MRMS:  state_d = S_MPK;
      S_MPK:   state_d = S_OUT;
      S_OUT:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        sum_q[c]  <= '0;
        cnt_q[c]  <= '0;
        peak_q[c] <= '0;
        ovf_q[c]  <= 1'b0;
      end
    end else begin
      state_q <= state_d;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      // accumulate one sample into its channel
      if (state_q == S_ACC && in_range) begin
        if (mag > peak_q[ch_q]) peak_q[ch_q] <= mag;
        if (cnt_q[ch_q] < {1'b0, {CNT_W{1'b1}}}) begin
          sum_q[ch_q] <= sum_q[ch_q] + 64'(sq);
          cnt_q[ch_q] <= cnt_q[ch_q] + 1'b1;
        end else begin
          ovf_q[ch_q] <= 1'b1;
        end
      end
      if (state_q == S_OUT) begin
        out_valid_q     <= 1'b1;
        sum_q[ch_q]  <= '0;
        cnt_q[ch_q]  <= '0;
        peak_q[ch_q] <= '0;
        ovf_q[ch_q]  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) item_q <= in_item_i;
    if (state_q == S_WSUM && lrsp.done) lsum_q <= lrsp.value;
    if (state_q == S_WCNT && lrsp.done) lcnt_q <= lrsp.value;
    if (state_q == S_WPK  && lrsp.done) lpk_q  <= lrsp.value;
    if (state_q == S_MRMS) begin
      // zero sum floors; count is nonzero once a sample was taken
      rms_q <= (sum_q[ch_q] == '0) ? armpm_pkg::DB_FLOOR : to_db(prod);
    end
    if (state_q == S_MPK) begin
      out_q.result_channel <= item_q.channel;
      out_q.rms_db         <= rms_q;
      out_q.peak_db        <= (peak_q[ch_q] == '0) ? armpm_pkg::DB_FLOOR : to_db(prod);
    end
    if (state_q == S_OUT) out_q.overflowed <= ovf_q[ch_q];
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // a result only appears after the sequencer finishes a window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_OUT)
    else $error("result without finished window");

  // no input is taken while a result is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !in_ready_o)
    else $error("input accepted with result pending");

  // log unit is only started from a request state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    lreq.start |-> (state_q == S_LSUM || state_q == S_LCNT || state_q == S_LPK))
    else $error("stray log request");

endmodule
